@@ hw/rtl/rcpp_pkg.sv @@
// Shared constants and types for the remote commander packet parser.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package rcpp_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [7:0] SUM_GOOD    = 8'hFF;
    localparam int         DATA_LEN    = 6;
    localparam int         POS_W       = 3;
    localparam logic [POS_W-1:0] CHECK_POS = POS_W'(DATA_LEN);

    // Six data bytes of one packet, byte 0 in slot 0
    typedef logic [DATA_LEN-1:0][7:0] t_payload;

    // Status of the byte being parsed this cycle
    typedef struct packed {
        logic good;     // checksum byte of a good packet
        logic last;     // checksum byte, good or bad
    } t_parse_status;

endpackage

@@ hw/rtl/rcpp_parser.sv @@
// Header hunt, byte position, running checksum and payload store.
// Depends on rcpp_pkg.
module rcpp_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  logic [7:0]             i_byte,
    output rcpp_pkg::t_parse_status o_status,
    output rcpp_pkg::t_payload     o_payload
);

    logic                         r_hunting, n_hunting;
    logic [rcpp_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [7:0]                   r_sum, n_sum;
    rcpp_pkg::t_payload           r_payload;
    logic [7:0]                   sum_with_byte;

    assign sum_with_byte = r_sum + i_byte;

    // Work out the next parse state for the byte held at the input
    always_comb begin
        n_hunting = r_hunting;
        n_pos     = r_pos;
        n_sum     = r_sum;
        o_status  = '0;
        if (r_hunting) begin
            if (i_byte == rcpp_pkg::HEADER_BYTE) begin
                n_hunting = 1'b0;
                n_pos     = '0;
                n_sum     = '0;
            end
        end else if (r_pos == '0 && i_byte == rcpp_pkg::HEADER_BYTE) begin
            // a second header byte drops back to the hunt
            n_hunting = 1'b1;
        end else begin
            n_sum = sum_with_byte;
            if (r_pos == rcpp_pkg::CHECK_POS) begin
                n_hunting     = 1'b1;
                n_pos         = '0;
                o_status.last = 1'b1;
                o_status.good = (sum_with_byte == rcpp_pkg::SUM_GOOD);
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    // Advance control state once the byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting <= 1'b1;
            r_pos     <= '0;
            r_sum     <= '0;
        end else if (i_advance) begin
            r_hunting <= n_hunting;
            r_pos     <= n_pos;
            r_sum     <= n_sum;
        end
    end

    // Store data bytes in their slots
    always_ff @(posedge i_clk) begin
        if (i_advance && !r_hunting && r_pos < rcpp_pkg::CHECK_POS &&
            !(r_pos == '0 && i_byte == rcpp_pkg::HEADER_BYTE)) begin
            r_payload[r_pos] <= i_byte;
        end
    end

    assign o_payload = r_payload;

endmodule

@@ hw/rtl/rcpp_result.sv @@
// Result register: maps the payload bytes to stick, pan/tilt and button fields.
// Depends on rcpp_pkg.
module rcpp_result (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_out_stall,
    input  logic                i_southpaw,
    input  rcpp_pkg::t_payload  i_payload,
    output logic                o_valid,
    output logic signed [7:0]   o_walk_vertical,
    output logic signed [8:0]   o_walk_horizontal,
    output logic signed [7:0]   o_look_vertical,
    output logic signed [7:0]   o_look_horizontal,
    output logic [15:0]         o_pan_word,
    output logic [15:0]         o_tilt_word,
    output logic [7:0]          o_button_bits,
    output logic [7:0]          o_extension_bits
);

    logic               r_valid;
    logic signed [7:0]  r_walk_v, r_look_v, r_look_h;
    logic signed [8:0]  r_walk_h;
    logic [15:0]        r_pan, r_tilt;
    logic [7:0]         r_button, r_ext;
    logic signed [7:0]  c0, c1, c2, c3;
    logic signed [7:0]  walk_h_base;
    logic signed [8:0]  n_walk_h;

    // Centre each stick byte: minus 128 is a flip of the top bit
    assign c0 = i_payload[0] ^ 8'h80;
    assign c1 = i_payload[1] ^ 8'h80;
    assign c2 = i_payload[2] ^ 8'h80;
    assign c3 = i_payload[3] ^ 8'h80;

    // Pick the walk horizontal source and apply the trim
    assign walk_h_base = i_southpaw ? c1 : c3;
    assign n_walk_h    = i_southpaw ? (9'(walk_h_base) + 9'sd1)
                                    : (9'(walk_h_base) - 9'sd1);

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_walk_v <= i_southpaw ? c0 : c2;
            r_walk_h <= n_walk_h;
            r_look_v <= i_southpaw ? c2 : c0;
            r_look_h <= i_southpaw ? c3 : c1;
            r_pan    <= {i_payload[0], i_payload[1]};
            r_tilt   <= {i_payload[2], i_payload[3]};
            r_button <= i_payload[4];
            r_ext    <= i_payload[5];
        end
    end

    assign o_valid           = r_valid;
    assign o_walk_vertical   = r_walk_v;
    assign o_walk_horizontal = r_walk_h;
    assign o_look_vertical   = r_look_v;
    assign o_look_horizontal = r_look_h;
    assign o_pan_word        = r_pan;
    assign o_tilt_word       = r_tilt;
    assign o_button_bits     = r_button;
    assign o_extension_bits  = r_ext;

endmodule

@@ hw/rtl/remote_commander_packet_parser_top.sv @@
// Top level of the remote commander packet parser: input register, mode
// register, parser and result register. Depends on rcpp_pkg, rcpp_parser, rcpp_result.
//
// Takes one received byte per clock. A packet is a 0xFF header, six data bytes
// and a checksum byte; the seven bytes after the header must sum to 0xFF mod 256.
// Each good packet gives one result: its checksum byte is held in the input register,
// then the result register. Bytes flow at one per cycle while the result side does
// not stall; a stalled result only holds back the checksum byte of the next good
// packet and the bytes behind it, other bytes keep moving. The southpaw mode
// register is always ready and must be written while no packet is in flight.
module remote_commander_packet_parser_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_southpaw_mode,
    // byte input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [7:0]  o_walk_vertical,
    output logic signed [8:0]  o_walk_horizontal,
    output logic signed [7:0]  o_look_vertical,
    output logic signed [7:0]  o_look_horizontal,
    output logic [15:0]        o_pan_word,
    output logic [15:0]        o_tilt_word,
    output logic [7:0]         o_button_bits,
    output logic [7:0]         o_extension_bits
);

    logic                    r_southpaw;
    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    out_free;
    logic                    advance;
    logic                    load;
    logic                    in_accept;
    rcpp_pkg::t_parse_status status;
    rcpp_pkg::t_payload      payload;

    // Mode register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_southpaw <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_southpaw <= i_cfg_southpaw_mode;
        end
    end

    // Consume the held item unless it has a result with nowhere to go
    assign out_free   = !o_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (out_free || !status.good);
    assign load       = advance && status.good;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || o_in_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    rcpp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_status  (status),
        .o_payload (payload)
    );

    rcpp_result u_result (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (load),
        .i_out_stall       (i_out_stall),
        .i_southpaw        (r_southpaw),
        .i_payload         (payload),
        .o_valid           (o_out_valid),
        .o_walk_vertical   (o_walk_vertical),
        .o_walk_horizontal (o_walk_horizontal),
        .o_look_vertical   (o_look_vertical),
        .o_look_horizontal (o_look_horizontal),
        .o_pan_word        (o_pan_word),
        .o_tilt_word       (o_tilt_word),
        .o_button_bits     (o_button_bits),
        .o_extension_bits  (o_extension_bits)
    );

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(load && o_out_valid && i_out_stall))
        else $error("result overwritten while stalled");

    // A good packet shows up at the output in the next cycle
    a_good_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_out_valid)
        else $error("good packet gave no result");

    // Only a checksum byte can be good
    a_good_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.good |-> status.last)
        else $error("good flag outside checksum byte");

endmodule

@@ tb/remote_commander_packet_parser_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for remote_commander_packet_parser_top: byte driver, result
// monitor and a cycle-free packet parser predictor. Depends on rcpp_pkg and the RTL top.
module remote_commander_packet_parser_top_tb;

    localparam int CLK_HIGH      = 4;
    localparam int CLK_LOW       = 4;
    localparam int RESET_CYCLES  = 3;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BYTES   = 290;
    localparam int PACKET_BYTES  = rcpp_pkg::DATA_LEN + 1;

    // One decoded command frame, as the block presents it
    typedef struct {
        logic signed [7:0] walk_v;
        logic signed [8:0] walk_h;
        logic signed [7:0] look_v;
        logic signed [7:0] look_h;
        logic [15:0]       pan;
        logic [15:0]       tilt;
        logic [7:0]        buttons;
        logic [7:0]        extension;
    } t_command_frame;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic i_cfg_southpaw_mode = 1'b0;
    logic i_in_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic i_out_stall = 1'b0;

    logic              o_cfg_ready;
    logic              o_in_stall;
    logic              o_out_valid;
    logic signed [7:0] o_walk_vertical;
    logic signed [8:0] o_walk_horizontal;
    logic signed [7:0] o_look_vertical;
    logic signed [7:0] o_look_horizontal;
    logic [15:0]       o_pan_word;
    logic [15:0]       o_tilt_word;
    logic [7:0]        o_button_bits;
    logic [7:0]        o_extension_bits;

    // Stimulus and expectation stores
    logic [7:0]     rx_byte_queue[$];
    t_command_frame frames_due[$];

    // Predictor state, reset values
    logic               seeking_header = 1'b1;
    logic [2:0]         bytes_seen = '0;
    logic [7:0]         byte_sum = '0;
    rcpp_pkg::t_payload held_bytes = '0;
    logic               southpaw = 1'b0;

    // Handshake bookkeeping, updated at the rising edge
    logic rx_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic all_quiet = 1'b0;

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;

    int error_count = 0;
    int bytes_sent = 0;
    int good_packets = 0;
    int bad_packets = 0;
    int header_aborts = 0;
    int southpaw_frames = 0;
    int frames_checked = 0;

    remote_commander_packet_parser_top DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_southpaw_mode (i_cfg_southpaw_mode),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_walk_vertical     (o_walk_vertical),
        .o_walk_horizontal   (o_walk_horizontal),
        .o_look_vertical     (o_look_vertical),
        .o_look_horizontal   (o_look_horizontal),
        .o_pan_word          (o_pan_word),
        .o_tilt_word         (o_tilt_word),
        .o_button_bits       (o_button_bits),
        .o_extension_bits    (o_extension_bits)
    );

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        begin
            error_count++;
            $display("%0t ERROR %s", $realtime, msg);
        end
    endtask

    // Byte minus 128 in two's complement is the byte with its top bit flipped
    function automatic logic signed [7:0] centred(input logic [7:0] b);
        return signed'(b ^ 8'h80);
    endfunction

    // Advance the parser predictor by one accepted byte; queue a frame on a good packet
    task automatic parse_rx_byte(input logic [7:0] b);
        t_command_frame    f;
        logic signed [8:0] wide;
        begin
            if (seeking_header) begin
                if (b == rcpp_pkg::HEADER_BYTE) begin
                    seeking_header = 1'b0;
                    bytes_seen = '0;
                    byte_sum = '0;
                end
            end else if (bytes_seen == 0 && b == rcpp_pkg::HEADER_BYTE) begin
                // a second 0xFF straight after the header restarts the hunt
                seeking_header = 1'b1;
                header_aborts++;
            end else begin
                if (bytes_seen < rcpp_pkg::DATA_LEN)
                    held_bytes[bytes_seen] = b;
                byte_sum = byte_sum + b;
                bytes_seen = bytes_seen + 3'd1;
                if (bytes_seen == PACKET_BYTES) begin
                    seeking_header = 1'b1;
                    bytes_seen = '0;
                    if (byte_sum != rcpp_pkg::SUM_GOOD) begin
                        bad_packets++;
                    end else begin
                        good_packets++;
                        if (southpaw) begin
                            southpaw_frames++;
                            wide = centred(held_bytes[1]);
                            f.walk_v = centred(held_bytes[0]);
                            f.walk_h = wide + 9'sd1;
                            f.look_v = centred(held_bytes[2]);
                            f.look_h = centred(held_bytes[3]);
                        end else begin
                            wide = centred(held_bytes[3]);
                            f.look_v = centred(held_bytes[0]);
                            f.look_h = centred(held_bytes[1]);
                            f.walk_v = centred(held_bytes[2]);
                            f.walk_h = wide - 9'sd1;
                        end
                        f.pan = {held_bytes[0], held_bytes[1]};
                        f.tilt = {held_bytes[2], held_bytes[3]};
                        f.buttons = held_bytes[4];
                        f.extension = held_bytes[5];
                        frames_due.push_back(f);
                    end
                end
            end
        end
    endtask

    // Data byte with a bias towards the range edges
    function automatic logic [7:0] pick_data_byte();
        if ($urandom_range(3) != 0)
            return 8'($urandom_range(255));
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'h7F;
            2: return 8'h80;
            default: return 8'hFF;
        endcase
    endfunction

    // Queue header, six data bytes and checksum; a corrupt checksum is never good
    task automatic queue_packet(input rcpp_pkg::t_payload d, input bit corrupt);
        logic [7:0] chk;
        begin
            chk = rcpp_pkg::SUM_GOOD;
            for (int k = 0; k < rcpp_pkg::DATA_LEN; k++)
                chk = chk - d[k];
            if (corrupt)
                chk = chk ^ 8'($urandom_range(1, 255));
            rx_byte_queue.push_back(rcpp_pkg::HEADER_BYTE);
            for (int k = 0; k < rcpp_pkg::DATA_LEN; k++)
                rx_byte_queue.push_back(d[k]);
            rx_byte_queue.push_back(chk);
        end
    endtask

    task automatic queue_good_packet();
        rcpp_pkg::t_payload d;
        begin
            for (int k = 0; k < rcpp_pkg::DATA_LEN; k++)
                d[k] = pick_data_byte();
            queue_packet(d, 1'b0);
        end
    endtask

    // Mostly well-formed packets, with bad checksums, line noise and broken packets mixed in
    task automatic queue_random_traffic(input int n_bytes);
        rcpp_pkg::t_payload d;
        int                 start;
        int                 pick;
        begin
            start = rx_byte_queue.size();
            while (rx_byte_queue.size() - start < n_bytes) begin
                pick = $urandom_range(99);
                if (pick < 78) begin
                    for (int k = 0; k < rcpp_pkg::DATA_LEN; k++)
                        d[k] = pick_data_byte();
                    queue_packet(d, pick >= 66);
                end else if (pick < 86) begin
                    repeat ($urandom_range(1, 4))
                        rx_byte_queue.push_back(8'($urandom_range(255)));
                end else if (pick < 93) begin
                    rx_byte_queue.push_back(rcpp_pkg::HEADER_BYTE);
                    rx_byte_queue.push_back(rcpp_pkg::HEADER_BYTE);
                end else begin
                    rx_byte_queue.push_back(rcpp_pkg::HEADER_BYTE);
                    repeat ($urandom_range(1, rcpp_pkg::DATA_LEN))
                        rx_byte_queue.push_back(pick_data_byte());
                end
            end
        end
    endtask

    // Wait for the stream to drain; finish any half-parsed packet so the parser is hunting
    task automatic settle_stream();
        bit done;
        begin
            done = 1'b0;
            while (!done) begin
                do @(negedge i_clk); while (!all_quiet);
                repeat (SETTLE_CYCLES) @(negedge i_clk);
                if (seeking_header) begin
                    done = all_quiet;
                end else if (bytes_seen == 0) begin
                    rx_byte_queue.push_back(rcpp_pkg::HEADER_BYTE);
                end else begin
                    repeat (PACKET_BYTES - bytes_seen)
                        rx_byte_queue.push_back(8'h00);
                end
            end
        end
    endtask

    task automatic write_southpaw(input logic mode);
        begin
            @(negedge i_clk);
            i_cfg_valid = 1'b1;
            i_cfg_southpaw_mode = mode;
            do @(negedge i_clk); while (!cfg_taken);
            i_cfg_valid = 1'b0;
            i_cfg_southpaw_mode = 1'b0;
        end
    endtask

    // Byte driver: hold an offered item until taken, otherwise offer or idle
    always @(negedge i_clk) begin
        if (!i_in_valid || rx_taken) begin
            if (rx_byte_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                i_in_valid <= 1'b1;
                i_rx_byte <= rx_byte_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // Monitor: track handshakes, run the predictor, check each result against the oldest frame
    always @(posedge i_clk) begin
        t_command_frame want;
        rx_taken <= i_rst_n && i_in_valid && !o_in_stall;
        cfg_taken <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                southpaw = i_cfg_southpaw_mode;
            if (i_in_valid && !o_in_stall) begin
                bytes_sent++;
                parse_rx_byte(i_rx_byte);
            end
            if (o_out_valid && !i_out_stall) begin
                if (frames_due.size() == 0) begin
                    flag_error("result item with no frame expected");
                end else begin
                    want = frames_due.pop_front();
                    frames_checked++;
                    if (o_walk_vertical !== want.walk_v)
                        flag_error($sformatf("walk_vertical %0d, expected %0d",
                                             o_walk_vertical, want.walk_v));
                    if (o_walk_horizontal !== want.walk_h)
                        flag_error($sformatf("walk_horizontal %0d, expected %0d",
                                             o_walk_horizontal, want.walk_h));
                    if (o_look_vertical !== want.look_v)
                        flag_error($sformatf("look_vertical %0d, expected %0d",
                                             o_look_vertical, want.look_v));
                    if (o_look_horizontal !== want.look_h)
                        flag_error($sformatf("look_horizontal %0d, expected %0d",
                                             o_look_horizontal, want.look_h));
                    if (o_pan_word !== want.pan)
                        flag_error($sformatf("pan_word %h, expected %h", o_pan_word, want.pan));
                    if (o_tilt_word !== want.tilt)
                        flag_error($sformatf("tilt_word %h, expected %h",
                                             o_tilt_word, want.tilt));
                    if (o_button_bits !== want.buttons)
                        flag_error($sformatf("button_bits %h, expected %h",
                                             o_button_bits, want.buttons));
                    if (o_extension_bits !== want.extension)
                        flag_error($sformatf("extension_bits %h, expected %h",
                                             o_extension_bits, want.extension));
                end
            end
        end
        all_quiet <= rx_byte_queue.size() == 0 && (!i_in_valid || !o_in_stall)
                     && frames_due.size() == 0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed bytes in the reset mode: noise while hunting, double header,
        // 0xFF as data, the walk_horizontal low extreme and a bad checksum
        rx_byte_queue.push_back(8'h12);
        rx_byte_queue.push_back(rcpp_pkg::HEADER_BYTE);
        rx_byte_queue.push_back(rcpp_pkg::HEADER_BYTE);
        // payload literals list byte 5 first
        queue_packet({8'h7F, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h00}, 1'b0);
        queue_packet({8'h7F, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h00}, 1'b1);
        queue_packet({8'h00, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h7F}, 1'b0);
        settle_stream();

        // Southpaw mode, walk_horizontal high extreme first, then lopsided idling
        write_southpaw(1'b1);
        queue_packet({8'hAA, 8'h55, 8'h80, 8'h01, 8'hFF, 8'hFE}, 1'b0);
        sender_idle_pct = 17;
        receiver_idle_pct = 58;
        queue_random_traffic(PHASE_BYTES);
        settle_stream();

        // Normal mode with the idling swapped round
        write_southpaw(1'b0);
        sender_idle_pct = 58;
        receiver_idle_pct = 17;
        queue_random_traffic(PHASE_BYTES);
        settle_stream();

        // Southpaw again at full rate; hold the result side off while good packets pile up
        write_southpaw(1'b1);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        repeat (8) queue_good_packet();
        hold_requests = hold_requests + 1;
        queue_random_traffic(PHASE_BYTES);
        settle_stream();

        $display("Covered %0d bytes: %0d good packets (%0d southpaw), %0d bad checksums,",
                 bytes_sent, good_packets, southpaw_frames, bad_packets);
        $display("%0d double-header restarts, %0d frames checked, %0d mismatches",
                 header_aborts, frames_checked, error_count);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/rcpp_pkg.sv
hw/rtl/rcpp_parser.sv
hw/rtl/rcpp_result.sv
hw/rtl/remote_commander_packet_parser_top.sv
tb/remote_commander_packet_parser_top_tb.sv
